// ===== design/lfb_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD framebuffer refresh sequencer package
// Shared constants, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfb_pkg;

  // Display geometry and framebuffer size.
  localparam int COLUMNS      = 128;
  localparam int HALF_COLUMNS = 64;
  localparam int BUFFER_BYTES = 1024;

  localparam int ADDR_W     = $clog2(BUFFER_BYTES);
  localparam int ADDR_SUM_W = ADDR_W + 1;
  localparam int SCAN_COL_W = $clog2(HALF_COLUMNS + 1);
  localparam int PAGE_W     = 3;
  localparam int CURSOR_W   = 16;

  localparam logic [PAGE_W-1:0] LAST_PAGE = 3'd7;
  localparam logic [7:0]        PAGE_CMD  = 8'hB8;
  localparam logic [7:0]        COL0_CMD  = 8'h40;

  // Chip select codes.
  localparam logic [1:0] CS_LEFT  = 2'd1;
  localparam logic [1:0] CS_RIGHT = 2'd2;
  localparam logic [1:0] CS_BOTH  = 2'd3;

  typedef enum logic [2:0] {
    OP_WRITE      = 3'd0,
    OP_SET_CURSOR = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_START      = 3'd3,
    OP_TICK       = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_PAGE,
    S_COL0,
    S_READ_L,
    S_EMIT_L,
    S_READ_R,
    S_EMIT_R
  } state_t;

  typedef enum logic [1:0] {
    EMIT_PAGE,
    EMIT_COL0,
    EMIT_LEFT,
    EMIT_RIGHT
  } emit_sel_t;

  typedef struct packed {
    logic      take;      // input request accepted this cycle
    logic      clear_we;  // write one zero of the clearing sweep
    logic      rd_left;
    logic      rd_right;
    logic      emit;
    emit_sel_t emit_sel;
    logic      col_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic refresh_active;
    logic col_zero;
    logic col_in_range;
    logic clear_last;
  } status_t;

endpackage

// ===== design/lfb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/lfb_datapath.sv =====
// ----------------------------------------------------------------------------
// Refresh sequencer datapath
// Framebuffer store, cursor, scan counters, clearing sweep and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfb_datapath (
  input  logic                clk,
  input  logic                rst,
  input  lfb_pkg::cmd_t       cmd,
  output lfb_pkg::status_t    status,
  input  logic [2:0]          opcode,
  input  logic [7:0]          data_byte,
  input  logic [6:0]          column,
  input  logic [2:0]          row,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [15:0]         m_tdata,  // [7:0] bus_byte, [9:8] chip_select
  output logic                m_tuser,  // [0] is_data
  output logic                m_tlast
);

  logic [lfb_pkg::CURSOR_W-1:0]   write_cursor;
  logic                           refresh_active;
  logic [lfb_pkg::SCAN_COL_W-1:0] scan_column;
  logic [lfb_pkg::PAGE_W-1:0]     scan_page;
  logic [lfb_pkg::ADDR_W-1:0]     clear_addr;

  logic [lfb_pkg::ADDR_SUM_W-1:0] base_addr;
  logic [lfb_pkg::ADDR_SUM_W-1:0] read_addr;
  logic                           read_ok;
  logic                           rd_valid;

  logic                           ram_we;
  logic [lfb_pkg::ADDR_W-1:0]     ram_waddr;
  logic [7:0]                     ram_wdata;
  logic                           ram_re;
  logic [7:0]                     ram_rdata;
  logic                           write_hit;
  logic [7:0]                     data_out;

  logic [7:0]                     bus_byte;
  logic [1:0]                     chip_select;

  assign write_hit = cmd.take && (opcode == lfb_pkg::OP_WRITE) &&
                     (write_cursor < lfb_pkg::CURSOR_W'(lfb_pkg::BUFFER_BYTES));

  assign base_addr = lfb_pkg::ADDR_SUM_W'(
                       lfb_pkg::ADDR_SUM_W'(scan_page) *
                       lfb_pkg::ADDR_SUM_W'(lfb_pkg::COLUMNS)) +
                     lfb_pkg::ADDR_SUM_W'(scan_column);
  assign read_addr = cmd.rd_right ?
                     base_addr + lfb_pkg::ADDR_SUM_W'(lfb_pkg::HALF_COLUMNS) : base_addr;
  assign read_ok   = read_addr < lfb_pkg::ADDR_SUM_W'(lfb_pkg::BUFFER_BYTES);

  assign ram_we    = cmd.clear_we || write_hit;
  assign ram_waddr = cmd.clear_we ? clear_addr : write_cursor[lfb_pkg::ADDR_W-1:0];
  assign ram_wdata = cmd.clear_we ? 8'h00 : data_byte;
  assign ram_re    = cmd.rd_left || cmd.rd_right;

  lfb_ram #(
    .WIDTH(8),
    .DEPTH(lfb_pkg::BUFFER_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(read_addr[lfb_pkg::ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  // An index past the end of the store reads as zero.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_valid <= read_ok;
    end
  end

  assign data_out = rd_valid ? ram_rdata : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_cursor   <= '0;
      refresh_active <= 1'b0;
      scan_column    <= '0;
      scan_page      <= '0;
    end else if (cmd.take) begin
      case (opcode)
        lfb_pkg::OP_WRITE: begin
          write_cursor <= write_cursor + 1'b1;
        end
        lfb_pkg::OP_SET_CURSOR: begin
          write_cursor <= lfb_pkg::CURSOR_W'(
                            lfb_pkg::CURSOR_W'(row) *
                            lfb_pkg::CURSOR_W'(lfb_pkg::COLUMNS)) +
                          lfb_pkg::CURSOR_W'(column) - 1'b1;
        end
        lfb_pkg::OP_START: begin
          refresh_active <= 1'b1;
        end
        lfb_pkg::OP_TICK: begin
          // The extra tick after a page's last column advances or ends the scan.
          if (refresh_active && !status.col_in_range) begin
            scan_column <= '0;
            if (scan_page < lfb_pkg::LAST_PAGE) begin
              scan_page <= scan_page + 1'b1;
            end else begin
              scan_page      <= '0;
              refresh_active <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.col_step) begin
      scan_column <= scan_column + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.take && (opcode == lfb_pkg::OP_CLEAR)) begin
      clear_addr <= '0;
    end else if (cmd.clear_we) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      lfb_pkg::EMIT_PAGE: begin
        bus_byte    = lfb_pkg::PAGE_CMD + 8'(scan_page);
        chip_select = lfb_pkg::CS_BOTH;
      end
      lfb_pkg::EMIT_COL0: begin
        bus_byte    = lfb_pkg::COL0_CMD;
        chip_select = lfb_pkg::CS_BOTH;
      end
      lfb_pkg::EMIT_LEFT: begin
        bus_byte    = data_out;
        chip_select = lfb_pkg::CS_LEFT;
      end
      default: begin
        bus_byte    = data_out;
        chip_select = lfb_pkg::CS_RIGHT;
      end
    endcase
  end

  // Result register: the next request is taken while a result still waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {6'b0, chip_select, bus_byte};
      m_tuser <= (cmd.emit_sel == lfb_pkg::EMIT_LEFT) ||
                 (cmd.emit_sel == lfb_pkg::EMIT_RIGHT);
      m_tlast <= (cmd.emit_sel == lfb_pkg::EMIT_RIGHT);
    end
  end

  assign status.out_free       = !m_tvalid || m_tready;
  assign status.refresh_active = refresh_active;
  assign status.col_zero       = (scan_column == '0);
  assign status.col_in_range   =
    scan_column < lfb_pkg::SCAN_COL_W'(lfb_pkg::HALF_COLUMNS);
  assign status.clear_last     =
    (clear_addr == lfb_pkg::ADDR_W'(lfb_pkg::BUFFER_BYTES - 1));

endmodule

// ===== design/lfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Refresh sequencer controller
// Sequences request intake, the clearing sweep and the bus bytes of a tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic [2:0]       opcode,
  input  lfb_pkg::status_t status,
  output logic             s_tready,
  output lfb_pkg::cmd_t    cmd
);

  lfb_pkg::state_t state;
  lfb_pkg::state_t state_next;

  // Reset starts with a sweep that zeroes the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfb_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lfb_pkg::S_IDLE: begin
        if (s_tvalid) begin
          if (opcode == lfb_pkg::OP_CLEAR) begin
            state_next = lfb_pkg::S_CLEAR;
          end else if ((opcode == lfb_pkg::OP_TICK) && status.refresh_active &&
                       status.col_in_range) begin
            state_next = status.col_zero ? lfb_pkg::S_PAGE : lfb_pkg::S_READ_L;
          end
        end
      end
      lfb_pkg::S_CLEAR: begin
        if (status.clear_last) begin
          state_next = lfb_pkg::S_IDLE;
        end
      end
      lfb_pkg::S_PAGE: begin
        if (status.out_free) begin
          state_next = lfb_pkg::S_COL0;
        end
      end
      lfb_pkg::S_COL0: begin
        if (status.out_free) begin
          state_next = lfb_pkg::S_READ_L;
        end
      end
      lfb_pkg::S_READ_L: begin
        state_next = lfb_pkg::S_EMIT_L;
      end
      lfb_pkg::S_EMIT_L: begin
        if (status.out_free) begin
          state_next = lfb_pkg::S_READ_R;
        end
      end
      lfb_pkg::S_READ_R: begin
        state_next = lfb_pkg::S_EMIT_R;
      end
      lfb_pkg::S_EMIT_R: begin
        if (status.out_free) begin
          state_next = lfb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lfb_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    cmd.take     = 1'b0;
    cmd.clear_we = 1'b0;
    cmd.rd_left  = 1'b0;
    cmd.rd_right = 1'b0;
    cmd.emit     = 1'b0;
    cmd.emit_sel = lfb_pkg::EMIT_PAGE;
    cmd.col_step = 1'b0;
    case (state)
      lfb_pkg::S_IDLE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
      end
      lfb_pkg::S_CLEAR: begin
        cmd.clear_we = 1'b1;
      end
      lfb_pkg::S_PAGE: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = lfb_pkg::EMIT_PAGE;
      end
      lfb_pkg::S_COL0: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = lfb_pkg::EMIT_COL0;
      end
      lfb_pkg::S_READ_L: begin
        cmd.rd_left = 1'b1;
      end
      lfb_pkg::S_EMIT_L: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = lfb_pkg::EMIT_LEFT;
      end
      lfb_pkg::S_READ_R: begin
        cmd.rd_right = 1'b1;
      end
      lfb_pkg::S_EMIT_R: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = lfb_pkg::EMIT_RIGHT;
        cmd.col_step = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/lcd_framebuffer_refresh_sequencer.sv =====
// ----------------------------------------------------------------------------
// LCD framebuffer refresh sequencer
// Page-organized 1024-byte framebuffer for a two-controller 128x64 LCD,
// walked on ticks into command and data bytes for both controllers.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                         Payload
// s_       in   s_tvalid s_tready s_tdata       opcode, data_byte, column, row
// m_       out  m_tvalid m_tready m_tdata       bus_byte, chip_select
//               m_tuser m_tlast                 is_data, last
//
// Write, set cursor, start and idle or extra ticks complete in the idle state.
// A data tick steps through PAGE and COL0 (at column zero only), then READ_L,
// EMIT_L, READ_R and EMIT_R: the store has a single read port and a one-deep result register.
// A clear writes one zero per cycle across the store.
// After reset a clearing pass zeroes the store before the first request.
// A stalled result register holds the sequence; requests wait on s_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_framebuffer_refresh_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [2:0] opcode, [10:3] data_byte, [17:11] column,
                                 // [20:18] row
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] bus_byte, [9:8] chip_select
  output logic        m_tuser,   // [0] is_data
  output logic        m_tlast
);

  lfb_pkg::cmd_t    cmd;
  lfb_pkg::status_t status;

  lfb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .opcode  (s_tdata[2:0]),
    .status  (status),
    .s_tready(s_tready),
    .cmd     (cmd)
  );

  lfb_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .opcode   (s_tdata[2:0]),
    .data_byte(s_tdata[10:3]),
    .column   (s_tdata[17:11]),
    .row      (s_tdata[20:18]),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // A result is only loaded into a free result register.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over a waiting result");

  // Data bytes go to one controller, never to both.
  a_data_one_chip: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[9:8] != lfb_pkg::CS_BOTH))
    else $error("data byte addressed to both controllers");

  // Once a store read is issued, the tick is still in progress.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_left || cmd.rd_right) |=> !s_tready)
    else $error("request accepted before the tick finished");

  // Only the right-half data byte closes a tick.
  a_last_right: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser && (m_tdata[9:8] == lfb_pkg::CS_RIGHT)))
    else $error("last marker on a result other than right-half data");

endmodule

// ===== sim/refresh_bus_checker.sv =====
// ----------------------------------------------------------------------------
// Refresh bus checker
// Watches both stream channels of the framebuffer refresh sequencer, keeps a
// shadow framebuffer and scan position, predicts the bus bytes of every tick
// and compares each result with the oldest predicted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module refresh_bus_checker
  import lfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          error_count,
  output int          outstanding,
  output int          requests_seen,
  output int          ticks_seen,
  output int          beats_seen,
  output int          passes_done
);

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic [1:0] chip_select;
    logic       last_flag;
  } bus_beat_t;

  logic [7:0]          shadow_frame [BUFFER_BYTES];
  logic [CURSOR_W-1:0] cursor;
  logic                refreshing;
  int unsigned         scan_col;
  logic [PAGE_W-1:0]   scan_page;
  bus_beat_t           pending_beats [$];
  bus_beat_t           oldest;

  function automatic bus_beat_t make_beat(logic is_data, logic [7:0] value, logic [1:0] cs);
    bus_beat_t beat;
    beat.is_data     = is_data;
    beat.bus_byte    = value;
    beat.chip_select = cs;
    beat.last_flag   = 1'b0;
    return beat;
  endfunction

  function automatic logic [7:0] frame_byte(int unsigned idx);
    return (idx < BUFFER_BYTES) ? shadow_frame[idx] : 8'h00;
  endfunction

  task automatic predict_bus_beats(input logic [23:0] word);
    logic [2:0]  op;
    logic [7:0]  data;
    logic [6:0]  col;
    logic [2:0]  row;
    bus_beat_t   beats [4];
    int          n;
    int unsigned base;
    int unsigned target;
    op   = word[2:0];
    data = word[10:3];
    col  = word[17:11];
    row  = word[20:18];
    n    = 0;
    case (op)
      OP_WRITE: begin
        // Writes past the end of the store are dropped but still move the cursor.
        if (cursor < BUFFER_BYTES) shadow_frame[cursor[ADDR_W-1:0]] = data;
        cursor = cursor + 1'b1;
      end
      OP_SET_CURSOR: begin
        target = int'(row) * COLUMNS + int'(col) + 32'h0000_FFFF;
        cursor = target[CURSOR_W-1:0];
      end
      OP_CLEAR: begin
        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      end
      OP_START: refreshing = 1'b1;
      OP_TICK: begin
        ticks_seen++;
        if (refreshing) begin
          if (scan_col == 0) begin
            beats[n] = make_beat(1'b0, PAGE_CMD + {5'b00000, scan_page}, CS_BOTH);
            n++;
            beats[n] = make_beat(1'b0, COL0_CMD, CS_BOTH);
            n++;
          end
          if (scan_col < HALF_COLUMNS) begin
            base = scan_col + int'(scan_page) * COLUMNS;
            beats[n] = make_beat(1'b1, frame_byte(base), CS_LEFT);
            n++;
            beats[n] = make_beat(1'b1, frame_byte(base + HALF_COLUMNS), CS_RIGHT);
            n++;
            scan_col++;
          end else if (scan_page < LAST_PAGE) begin
            scan_page++;
            scan_col = 0;
          end else begin
            scan_page  = '0;
            scan_col   = 0;
            refreshing = 1'b0;
            passes_done++;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      beats[i].last_flag = (i == n - 1);
      pending_beats.push_back(beats[i]);
    end
  endtask

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Results are taken before requests so that a request accepted on the same
  // edge can never satisfy a result that was already on the bus.
  always @(posedge clk) begin
    if (rst) begin
      foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      cursor        = '0;
      refreshing    = 1'b0;
      scan_col      = 0;
      scan_page     = '0;
      pending_beats.delete();
      error_count   = 0;
      requests_seen = 0;
      ticks_seen    = 0;
      beats_seen    = 0;
      passes_done   = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        beats_seen++;
        if (pending_beats.size() == 0) begin
          error_count++;
          $display("%0t: bus byte %02h with nothing expected: expected none, actual %04h",
                   $time, m_tdata[7:0], m_tdata);
        end else begin
          oldest = pending_beats.pop_front();
          check_field("is_data", oldest.is_data, m_tuser);
          check_field("bus_byte", oldest.bus_byte, m_tdata[7:0]);
          check_field("chip_select", oldest.chip_select, m_tdata[9:8]);
          check_field("last", oldest.last_flag, m_tlast);
        end
      end
      if (s_tvalid && s_tready) begin
        requests_seen++;
        predict_bus_beats(s_tdata);
      end
    end
    outstanding = pending_beats.size();
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Framebuffer refresh sequencer testbench
// Drives directed and random requests under three idling mixes, the last one
// with a long receiver hold-off; a separate checker predicts and compares
// every bus byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lfb_pkg::*;

  localparam int RESET_CYCLES     = 11;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int DRAIN_CYCLES     = 20;
  localparam int RANDOM_PER_PHASE = 60;

  // Opcodes the block has no use for.
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int error_count;
  int outstanding;
  int requests_seen;
  int ticks_seen;
  int beats_seen;
  int passes_done;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;
  int cycle_count;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lcd_framebuffer_refresh_sequencer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  refresh_bus_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .error_count   (error_count),
    .outstanding   (outstanding),
    .requests_seen (requests_seen),
    .ticks_seen    (ticks_seen),
    .beats_seen    (beats_seen),
    .passes_done   (passes_done)
  );

  function automatic logic [23:0] pack_request(logic [2:0] op, logic [7:0] data,
                                               logic [6:0] col, logic [2:0] row);
    return {3'b000, row, col, data, op};
  endfunction

  // Holds the request until it is taken; tvalid stays up into the next call.
  task automatic send_request(input logic [23:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random_request();
    int         pick;
    logic [2:0] op;
    pick = $urandom_range(99);
    if (pick < 45)      op = OP_TICK;
    else if (pick < 70) op = OP_WRITE;
    else if (pick < 82) op = OP_SET_CURSOR;
    else if (pick < 90) op = OP_START;
    else if (pick < 93) op = OP_CLEAR;
    else                op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    send_request(pack_request(op, 8'($urandom_range(255)), 7'($urandom_range(127)),
                              3'($urandom_range(7))));
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    m_tready  = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    send_idle_pct = 7;
    recv_idle_pct = 71;
    hold_req      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    send_request(pack_request(OP_TICK, 8'h00, 7'd0, 3'd0));       // idle tick
    send_request(pack_request(OP_SET_CURSOR, 8'h00, 7'd0, 3'd0)); // cursor wraps
    send_request(pack_request(OP_WRITE, 8'hA5, 7'd0, 3'd0));      // dropped
    send_request(pack_request(OP_WRITE, 8'hFF, 7'd127, 3'd7));
    send_request(pack_request(OP_WRITE, 8'h00, 7'd0, 3'd0));
    send_request(pack_request(OP_WRITE, 8'h5A, 7'd0, 3'd0));
    send_request(pack_request(OP_SET_CURSOR, 8'hFF, 7'd65, 3'd0));
    send_request(pack_request(OP_WRITE, 8'h81, 7'd0, 3'd0));
    send_request(pack_request(OP_SET_CURSOR, 8'h00, 7'd127, 3'd7));
    send_request(pack_request(OP_WRITE, 8'hC3, 7'd0, 3'd0));
    send_request(pack_request(OP_WRITE, 8'h3C, 7'd0, 3'd0));
    send_request(pack_request(OP_WRITE, 8'h99, 7'd0, 3'd0));      // past the end
    for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
      send_request(pack_request(3'(op), 8'hFF, 7'd127, 3'd7));
    send_request(pack_request(OP_START, 8'h00, 7'd0, 3'd0));
    send_request(pack_request(OP_TICK, 8'hFF, 7'd127, 3'd7));
    send_request(pack_request(OP_TICK, 8'h00, 7'd0, 3'd0));
    send_request(pack_request(OP_START, 8'h00, 7'd0, 3'd0));      // already running
    send_request(pack_request(OP_TICK, 8'h00, 7'd0, 3'd0));
    send_request(pack_request(OP_CLEAR, 8'h00, 7'd0, 3'd0));
    send_request(pack_request(OP_TICK, 8'h00, 7'd0, 3'd0));

    repeat (RANDOM_PER_PHASE) send_random_request();

    send_idle_pct = 71;
    recv_idle_pct = 7;
    repeat (RANDOM_PER_PHASE) send_random_request();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Back pressure: the receiver stops while ticks keep coming.
    send_request(pack_request(OP_START, 8'h00, 7'd0, 3'd0));
    hold_req = 1'b1;
    repeat (40) send_request(pack_request(OP_TICK, 8'($urandom_range(255)), 7'd0, 3'd0));
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests, %0d of them ticks, and checked %0d bus bytes.",
             requests_seen, ticks_seen, beats_seen);
    $display("%0d full refresh passes ended; one %0d-cycle receiver hold-off applied.",
             passes_done, HOLD_OFF_CYCLES);
    if (error_count == 0 && outstanding == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
